// ----- hw/rtl/bsca_pkg.sv -----
// shared constants and types of the byte store chunk allocator
package bsca_pkg;

  localparam int StoreBytes = 1024;
  localparam int StoreAw    = $clog2(StoreBytes);
  localparam int WalkW      = ((StoreAw > 16) ? StoreAw : 16) + 2;
  localparam int HdrBytes   = 5;
  localparam int SplitMin   = HdrBytes + 1;
  localparam int StageDepth = 1024;
  localparam int StageAw    = $clog2(StageDepth);
  localparam int CntW       = StageAw + 1;

  localparam logic [7:0] MagicByte = 8'(8'h1a << 1);
  localparam logic [7:0] MagicMask = 8'hfe;
  localparam logic [7:0] EraseByte = 8'hff;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_HREQ,
    S_HCAP,
    S_EVAL,
    S_HWR,
    S_COPY,
    S_RDREQ,
    S_RDCAP,
    S_FREEWR,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/bsca_if.sv -----
// request and response channel interfaces
interface bsca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] chunk_id;
  logic [9:0]  payload_length;
  logic [9:0]  byte_offset;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, operation, chunk_id, payload_length, byte_offset,
                  data_byte, last, input ready);
  modport sink (input valid, operation, chunk_id, payload_length, byte_offset,
                data_byte, last, output ready);
endinterface

interface bsca_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink (input valid, status, read_data, output ready);
endinterface

// ----- hw/rtl/bsca_ram.sv -----
// generic single write port ram with registered read
module bsca_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/byte_store_chunk_allocator.sv -----
// top level: chunk chain walker sequencer over the byte store
//
// channel | dir | beat contents
// in_i    | in  | operation, chunk_id, payload_length, byte_offset, data_byte, last
// out_o   | out | status, read_data
//
// a staged write byte is taken without leaving idle; read, free and a last write byte walk the chain
// header by header through the single store read port; a write then also writes its
// headers and copies each staged payload byte.
// after reset the store is erased to 0xff over all StoreBytes (1024) bytes before in_i is ready.
// a result waits in the output register; the next beat is taken meanwhile.
module byte_store_chunk_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  bsca_in_if.sink    in_i,
  bsca_out_if.source out_o
);

  bsca_pkg::state_e state_q, state_d;
  bsca_pkg::op_e    op_q, op_d;
  bsca_pkg::status_e status_q, status_d;

  logic [15:0]                  id_q, id_d;
  logic [9:0]                   len_q, len_d;
  logic [9:0]                   off_q, off_d;
  logic [bsca_pkg::WalkW-1:0]   addr_q, addr_d;
  logic [2:0]                   k_q, k_d;
  logic [7:0]                   hdr_q [5];
  logic [7:0]                   hdr_d [5];
  logic [7:0]                   hw_q [5];
  logic [7:0]                   hw_d [5];
  logic [bsca_pkg::WalkW-1:0]   hw_base_q, hw_base_d;
  logic                         oob_q, oob_d;
  logic                         split_q, split_d;
  logic                         split_phase_q, split_phase_d;
  logic [9:0]                   i_q, i_d;
  logic                         cp_v_q, cp_v_d;
  logic [bsca_pkg::WalkW-1:0]   cp_a_q, cp_a_d;
  logic [7:0]                   rdata_q, rdata_d;
  logic                         out_vld_q, out_vld_d;
  logic [1:0]                   out_status_q, out_status_d;
  logic [7:0]                   out_rdata_q, out_rdata_d;
  logic [bsca_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [bsca_pkg::StoreAw-1:0] clr_q, clr_d;

  logic                         st_we;
  logic [bsca_pkg::StoreAw-1:0] st_waddr, st_raddr;
  logic [7:0]                   st_wdata, st_rdata;
  logic                         sg_we;
  logic [bsca_pkg::StageAw-1:0] sg_raddr;
  logic [7:0]                   sg_rdata;

  logic                         in_acc;
  logic                         magic, is_free;
  logic [15:0]                  p, hid, split_len;
  logic [bsca_pkg::WalkW-1:0]   len_w, p_w, adv, end_w, wa, store_w;
  logic                         fits;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == bsca_pkg::S_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.status = out_status_q;
  assign out_o.read_data = out_rdata_q;

  assign sg_we = in_acc && (bsca_pkg::op_e'(in_i.operation) == bsca_pkg::OP_WRITE)
                 && !cnt_q[bsca_pkg::CntW-1];

  assign magic   = (hdr_q[0] & bsca_pkg::MagicMask) == bsca_pkg::MagicByte;
  assign is_free = hdr_q[0][0];
  assign p       = {hdr_q[4], hdr_q[3]};
  assign hid     = {hdr_q[2], hdr_q[1]};
  assign len_w   = bsca_pkg::WalkW'(len_q);
  assign p_w     = bsca_pkg::WalkW'(p);
  assign store_w = bsca_pkg::WalkW'(bsca_pkg::StoreBytes);
  assign adv     = addr_q + bsca_pkg::WalkW'(bsca_pkg::HdrBytes) + p_w;
  assign end_w   = addr_q + bsca_pkg::WalkW'(bsca_pkg::HdrBytes) + len_w;
  assign wa      = hw_base_q + bsca_pkg::WalkW'(k_q);
  assign split_len = p - 16'(len_q) - 16'(bsca_pkg::HdrBytes);
  assign fits = (p == 16'(len_q))
              ? (end_w + bsca_pkg::WalkW'(bsca_pkg::SplitMin) < store_w)
              : ((p_w >= len_w + bsca_pkg::WalkW'(bsca_pkg::SplitMin)) && (end_w < store_w));

  bsca_ram #(.Width(8), .Depth(bsca_pkg::StoreBytes)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  bsca_ram #(.Width(8), .Depth(bsca_pkg::StageDepth)) u_stage (
    .clk_i   (clk_i),
    .we_i    (sg_we),
    .waddr_i (cnt_q[bsca_pkg::StageAw-1:0]),
    .wdata_i (in_i.data_byte),
    .raddr_i (sg_raddr),
    .rdata_o (sg_rdata)
  );

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    status_d = status_q;
    id_d = id_q;
    len_d = len_q;
    off_d = off_q;
    addr_d = addr_q;
    k_d = k_q;
    hdr_d = hdr_q;
    hw_d = hw_q;
    hw_base_d = hw_base_q;
    oob_d = oob_q;
    split_d = split_q;
    split_phase_d = split_phase_q;
    i_d = i_q;
    cp_v_d = cp_v_q;
    cp_a_d = cp_a_q;
    rdata_d = rdata_q;
    out_vld_d = out_vld_q;
    out_status_d = out_status_q;
    out_rdata_d = out_rdata_q;
    cnt_d = cnt_q;
    clr_d = clr_q;
    st_we = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_raddr = '0;
    sg_raddr = '0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      bsca_pkg::S_CLEAR: begin
        st_we = 1'b1;
        st_waddr = clr_q;
        st_wdata = bsca_pkg::EraseByte;
        clr_d = clr_q + 1'b1;
        if (clr_q == bsca_pkg::StoreAw'(bsca_pkg::StoreBytes - 1)) begin
          state_d = bsca_pkg::S_IDLE;
        end
      end
      bsca_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d = bsca_pkg::op_e'(in_i.operation);
          id_d = in_i.chunk_id;
          len_d = in_i.payload_length;
          off_d = in_i.byte_offset;
          addr_d = '0;
          rdata_d = '0;
          unique case (bsca_pkg::op_e'(in_i.operation))
            bsca_pkg::OP_WRITE: begin
              if (!cnt_q[bsca_pkg::CntW-1]) begin
                cnt_d = cnt_q + 1'b1;
              end
              if (in_i.last) begin
                cnt_d = '0;
                state_d = bsca_pkg::S_CHK;
              end
            end
            bsca_pkg::OP_READ, bsca_pkg::OP_FREE: begin
              state_d = bsca_pkg::S_CHK;
            end
            default: begin
              state_d = bsca_pkg::S_IDLE;
            end
          endcase
        end
      end
      bsca_pkg::S_CHK: begin
        k_d = '0;
        if (op_q == bsca_pkg::OP_WRITE) begin
          if (addr_q + len_w + bsca_pkg::WalkW'(bsca_pkg::HdrBytes) < store_w) begin
            state_d = bsca_pkg::S_HREQ;
          end else begin
            status_d = bsca_pkg::ST_NO_SPACE;
            state_d = bsca_pkg::S_DONE;
          end
        end else if (addr_q < store_w) begin
          state_d = bsca_pkg::S_HREQ;
        end else begin
          status_d = bsca_pkg::ST_NOT_FOUND;
          state_d = bsca_pkg::S_DONE;
        end
      end
      bsca_pkg::S_HREQ: begin
        st_raddr = bsca_pkg::StoreAw'(addr_q + bsca_pkg::WalkW'(k_q));
        oob_d = (addr_q + bsca_pkg::WalkW'(k_q)) >= store_w;
        state_d = bsca_pkg::S_HCAP;
      end
      bsca_pkg::S_HCAP: begin
        hdr_d[k_q] = oob_q ? bsca_pkg::EraseByte : st_rdata;
        if (k_q == 3'd4) begin
          state_d = bsca_pkg::S_EVAL;
        end else begin
          k_d = k_q + 3'd1;
          state_d = bsca_pkg::S_HREQ;
        end
      end
      bsca_pkg::S_EVAL: begin
        k_d = '0;
        if (op_q == bsca_pkg::OP_WRITE) begin
          if (!magic || (p != 16'd0 && is_free && fits)) begin
            split_d = magic && (p != 16'(len_q));
            split_phase_d = 1'b0;
            hw_d[0] = bsca_pkg::MagicByte;
            hw_d[1] = id_q[7:0];
            hw_d[2] = id_q[15:8];
            hw_d[3] = len_q[7:0];
            hw_d[4] = 8'(len_q[9:8]);
            hw_base_d = addr_q;
            state_d = bsca_pkg::S_HWR;
          end else begin
            addr_d = adv;
            state_d = bsca_pkg::S_CHK;
          end
        end else if (!magic) begin
          status_d = bsca_pkg::ST_NOT_FOUND;
          state_d = bsca_pkg::S_DONE;
        end else if (!is_free && hid == id_q) begin
          if (op_q == bsca_pkg::OP_FREE) begin
            state_d = bsca_pkg::S_FREEWR;
          end else if (addr_q + bsca_pkg::WalkW'(bsca_pkg::HdrBytes)
                       + bsca_pkg::WalkW'(off_q) >= store_w) begin
            status_d = bsca_pkg::ST_RANGE;
            state_d = bsca_pkg::S_DONE;
          end else begin
            state_d = bsca_pkg::S_RDREQ;
          end
        end else begin
          addr_d = adv;
          state_d = bsca_pkg::S_CHK;
        end
      end
      bsca_pkg::S_HWR: begin
        st_we = wa < store_w;
        st_waddr = bsca_pkg::StoreAw'(wa);
        st_wdata = hw_q[k_q];
        if (k_q == 3'd4) begin
          if (split_phase_q) begin
            status_d = bsca_pkg::ST_OK;
            state_d = bsca_pkg::S_DONE;
          end else begin
            i_d = '0;
            cp_v_d = 1'b0;
            state_d = bsca_pkg::S_COPY;
          end
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      bsca_pkg::S_COPY: begin
        if (cp_v_q) begin
          st_we = cp_a_q < store_w;
          st_waddr = bsca_pkg::StoreAw'(cp_a_q);
          st_wdata = sg_rdata;
        end
        if (i_q != len_q) begin
          sg_raddr = bsca_pkg::StageAw'(i_q);
          cp_v_d = 1'b1;
          cp_a_d = end_w - len_w + bsca_pkg::WalkW'(i_q);
          i_d = i_q + 10'd1;
        end else begin
          cp_v_d = 1'b0;
          if (!cp_v_q) begin
            if (split_q) begin
              hw_d[0] = bsca_pkg::MagicByte | 8'h01;
              hw_d[1] = 8'h00;
              hw_d[2] = 8'h00;
              hw_d[3] = split_len[7:0];
              hw_d[4] = split_len[15:8];
              hw_base_d = end_w;
              k_d = '0;
              split_phase_d = 1'b1;
              state_d = bsca_pkg::S_HWR;
            end else begin
              status_d = bsca_pkg::ST_OK;
              state_d = bsca_pkg::S_DONE;
            end
          end
        end
      end
      bsca_pkg::S_RDREQ: begin
        st_raddr = bsca_pkg::StoreAw'(addr_q + bsca_pkg::WalkW'(bsca_pkg::HdrBytes)
                                      + bsca_pkg::WalkW'(off_q));
        state_d = bsca_pkg::S_RDCAP;
      end
      bsca_pkg::S_RDCAP: begin
        rdata_d = st_rdata;
        status_d = bsca_pkg::ST_OK;
        state_d = bsca_pkg::S_DONE;
      end
      bsca_pkg::S_FREEWR: begin
        st_we = 1'b1;
        st_waddr = bsca_pkg::StoreAw'(addr_q);
        st_wdata = hdr_q[0] | 8'h01;
        status_d = bsca_pkg::ST_OK;
        state_d = bsca_pkg::S_DONE;
      end
      bsca_pkg::S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_status_d = status_q;
          out_rdata_d = rdata_q;
          state_d = bsca_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bsca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsca_pkg::S_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      out_vld_q <= 1'b0;
      cp_v_q <= 1'b0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      out_vld_q <= out_vld_d;
      cp_v_q <= cp_v_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    status_q <= status_d;
    id_q <= id_d;
    len_q <= len_d;
    off_q <= off_d;
    addr_q <= addr_d;
    hdr_q <= hdr_d;
    hw_q <= hw_d;
    hw_base_q <= hw_base_d;
    oob_q <= oob_d;
    split_q <= split_d;
    split_phase_q <= split_phase_d;
    i_q <= i_d;
    cp_a_q <= cp_a_d;
    rdata_q <= rdata_d;
    out_status_q <= out_status_d;
    out_rdata_q <= out_rdata_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bsca_pkg::CntW'(bsca_pkg::StageDepth))
    else $error("staged count beyond staging depth");

  a_last_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.operation == bsca_pkg::OP_WRITE && in_i.last)
    |=> (state_q == bsca_pkg::S_CHK && cnt_q == '0))
    else $error("last write beat did not start allocation");

  a_no_write_while_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsca_pkg::S_HREQ || state_q == bsca_pkg::S_HCAP) |-> !st_we)
    else $error("store written during header walk");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsca_pkg::S_DONE && (!out_vld_q || out_o.ready)) |=> out_vld_q)
    else $error("result lost on completion");
`endif

endmodule
